// ===== rtl/spis_pkg.sv =====
// ----------------------------------------------------------------------------
// spis_pkg: shared types and constants of the Stokeslet image sum block
// Widths of the fixed-point datapath, command and result types, and the
// table of tensor entries.
// ----------------------------------------------------------------------------
`default_nettype none

package spis_pkg;

  localparam int COORD_W      = 32;
  localparam int DIFF_W       = 33;
  localparam int RX_W         = 34;
  localparam int MIN_DIST_W   = 16;
  localparam int NEAR_W       = 4;
  localparam int FAR_W        = 11;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int OPCODE_W     = 2;
  localparam int A_W          = 31;
  localparam int D2_W         = 64;
  localparam int N_W          = 32;
  localparam int DIV_W        = 64;
  localparam int E_W          = 31;
  localparam int K_W          = 28;
  localparam int P_W          = 44;
  localparam int M_W          = 32;
  localparam int T_W          = 62;
  localparam int G_W          = 46;
  localparam int SUM_W        = 64;
  localparam int OUT_W        = 48;
  localparam int ENTRIES      = 6;
  localparam int ENTRY_W      = 3;
  localparam int PERIOD_SHIFT = 16;
  localparam int SCALE_SHIFT  = 30;
  localparam int INV_SHIFT    = 48;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 64;
  localparam int CNT_W        = 6;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam int DEF_MAX_FAR_IMAGES  = 1024;
  localparam int DEF_MAX_NEAR_LAYERS = 15;

  // round(2^32 / (8*pi))
  localparam logic [K_W-1:0] KERNEL_SCALE = 28'd170891319;

  localparam logic [MIN_DIST_W-1:0] MIN_DISTANCE_RST = 16'd1;
  localparam logic [NEAR_W-1:0]     NEAR_LAYERS_RST  = 4'd1;
  localparam logic [FAR_W-1:0]      FAR_LIMIT_RST    = 11'd1000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SINGLE = 2'd0,
    OP_NEAR   = 2'd1,
    OP_FAR    = 2'd2
  } opcode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_DISTANCE = 2'd0,
    CFG_NEAR_LAYERS  = 2'd1,
    CFG_FAR_LIMIT    = 2'd2
  } cfg_addr_e;

  typedef struct packed {
    logic [MIN_DIST_W-1:0] min_distance;
    logic [NEAR_W-1:0]     near_layers;
    logic [FAR_W-1:0]      far_limit;
  } cfg_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]        op;
    logic [2:0][DIFF_W-1:0]     d;
  } cmd_t;

  typedef struct packed {
    logic [2:0][RX_W-1:0] r;
  } kreq_t;

  typedef struct packed {
    logic               valid;
    logic [ENTRY_W-1:0] entry;
    logic               negate;
    logic [G_W-1:0]     mag;
  } contrib_t;

  typedef logic [ENTRIES-1:0][OUT_W-1:0] result_t;

  // Row and column of each stored entry: xx, xy, xz, yy, yz, zz.
  function automatic logic [1:0] pair_row(input logic [ENTRY_W-1:0] ent);
    logic [1:0] r;
    case (ent)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_col(input logic [ENTRY_W-1:0] ent);
    logic [1:0] c;
    case (ent)
      3'd0:       c = 2'd0;
      3'd1, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spis_intf.sv =====
// ----------------------------------------------------------------------------
// spis_intf: channel interfaces of the Stokeslet image sum block
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface spis_in_if import spis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [COORD_W-1:0]  target_x;
  logic signed [COORD_W-1:0]  target_y;
  logic signed [COORD_W-1:0]  target_z;
  logic signed [COORD_W-1:0]  source_x;
  logic signed [COORD_W-1:0]  source_y;
  logic signed [COORD_W-1:0]  source_z;

  modport source (output valid, opcode, target_x, target_y, target_z,
                  source_x, source_y, source_z, input ready);
  modport sink (input valid, opcode, target_x, target_y, target_z,
                source_x, source_y, source_z, output ready);
endinterface

interface spis_out_if import spis_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  g_xx;
  logic signed [OUT_W-1:0]  g_xy;
  logic signed [OUT_W-1:0]  g_xz;
  logic signed [OUT_W-1:0]  g_yy;
  logic signed [OUT_W-1:0]  g_yz;
  logic signed [OUT_W-1:0]  g_zz;

  modport source (output valid, g_xx, g_xy, g_xz, g_yy, g_yz, g_zz, input ready);
  modport sink (input valid, g_xx, g_xy, g_xz, g_yy, g_yz, g_zz, output ready);
endinterface

interface spis_cfg_if import spis_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/spis_front.sv =====
// ----------------------------------------------------------------------------
// spis_front: input stage of the Stokeslet image sum block
// Accepts items, forms the displacement target - source and queues the
// resulting commands for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module spis_front import spis_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spis_in_if.sink    in_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  wire logic  cmd_pop_i
);

  cmd_t                cmd_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q;
  cmd_t                new_cmd;
  logic                push, pop;

  assign in_i.ready  = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = cmd_q[rd_ptr_q];

  always_comb begin
    new_cmd.op   = in_i.opcode;
    new_cmd.d[0] = {in_i.target_x[COORD_W-1], in_i.target_x}
                 - {in_i.source_x[COORD_W-1], in_i.source_x};
    new_cmd.d[1] = {in_i.target_y[COORD_W-1], in_i.target_y}
                 - {in_i.source_y[COORD_W-1], in_i.source_y};
    new_cmd.d[2] = {in_i.target_z[COORD_W-1], in_i.target_z}
                 - {in_i.source_z[COORD_W-1], in_i.source_z};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) cmd_q[wr_ptr_q] <= new_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/spis_kernel.sv =====
// ----------------------------------------------------------------------------
// spis_kernel: iterative Oseen tensor kernel
// Evaluates one image: square sum, digit-by-digit square root, four radix-2
// dividers in parallel, then six tensor entries through one multiplier path.
// ----------------------------------------------------------------------------
`default_nettype none

module spis_kernel import spis_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire kreq_t                  req_i,
  input  wire logic [MIN_DIST_W-1:0]  min_distance_i,
  output contrib_t                    contrib_o,
  output logic                        done_o
);

  typedef enum logic [3:0] {
    K_IDLE, K_SQUARE, K_CHECK, K_SQRT, K_DIVIDE,
    K_PLO, K_PHI, K_MPROD, K_GLO, K_GHI
  } kstate_e;

  kstate_e             state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ENTRY_W-1:0]  ent_q;
  logic                done_q, cval_q;

  logic [A_W-1:0]      a_q [3];
  logic [2:0]          neg_q;
  logic [1:0]          s_q;
  logic [D2_W-1:0]     d2_q, x_q, res_q, bit_q;
  logic [N_W-1:0]      n_q;
  logic [DIV_W-1:0]    num_q [4];
  logic [DIV_W-1:0]    quo_q [4];
  logic [N_W-1:0]      rem_q [4];
  logic [T_W-1:0]      t_q;
  logic [P_W-1:0]      p_q;
  logic [M_W-1:0]      m_q;
  logic [G_W-1:0]      g_q;
  logic [ENTRY_W-1:0]  centry_q;
  logic                cneg_q;

  logic [RX_W-1:0]       mag_c [3];
  logic [RX_W-1:0]       mx_c;
  logic [1:0]            shift_c;
  logic [2*A_W-1:0]      sq_c;
  logic [2*MIN_DIST_W-1:0] md2_c;
  logic                  too_close_c;
  logic [D2_W:0]         trial_c;
  logic [D2_W-1:0]       x_nx, res_nx;
  logic [N_W:0]          rem2_c [4];
  logic [N_W:0]          diff_c [4];
  logic                  ge_c [4];
  logic [1:0]            row_c, col_c;
  logic [E_W-1:0]        ea_c, eb_c;
  logic [2*E_W-1:0]      eprod_c;
  logic [M_W-1:0]        m_c;
  logic [T_W-1:0]        plo_c, glo_c;
  logic [P_W:0]          phi_c;
  logic [G_W:0]          ghi_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = req_i.r[k][RX_W-1] ? (RX_W'(0) - req_i.r[k]) : req_i.r[k];
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
    if (mx_c[RX_W-1:31] == '0)      shift_c = 2'd0;
    else if (mx_c[RX_W-1:32] == '0) shift_c = 2'd1;
    else                            shift_c = 2'd2;

    sq_c  = (2*A_W)'(a_q[cnt_q[1:0]]) * (2*A_W)'(a_q[cnt_q[1:0]]);
    md2_c = (2*MIN_DIST_W)'(min_distance_i) * (2*MIN_DIST_W)'(min_distance_i);
    // The distance floor applies only when no prescale was needed.
    too_close_c = (s_q == 2'd0) && ((d2_q == '0) || (d2_q < D2_W'(md2_c)));

    trial_c = {1'b0, res_q} + {1'b0, bit_q};
    if ({1'b0, x_q} >= trial_c) begin
      x_nx   = x_q - trial_c[D2_W-1:0];
      res_nx = (res_q >> 1) + bit_q;
    end else begin
      x_nx   = x_q;
      res_nx = res_q >> 1;
    end

    for (int l = 0; l < 4; l++) begin
      rem2_c[l] = {rem_q[l], num_q[l][DIV_W-1]};
      diff_c[l] = rem2_c[l] - {1'b0, n_q};
      ge_c[l]   = (rem2_c[l] >= {1'b0, n_q});
    end

    row_c = pair_row(ent_q);
    col_c = pair_col(ent_q);
    case (row_c)
      2'd0:    ea_c = quo_q[1][E_W-1:0];
      2'd1:    ea_c = quo_q[2][E_W-1:0];
      default: ea_c = quo_q[3][E_W-1:0];
    endcase
    case (col_c)
      2'd0:    eb_c = quo_q[1][E_W-1:0];
      2'd1:    eb_c = quo_q[2][E_W-1:0];
      default: eb_c = quo_q[3][E_W-1:0];
    endcase
    eprod_c = (2*E_W)'(ea_c) * (2*E_W)'(eb_c);
    m_c = eprod_c[2*E_W-1:SCALE_SHIFT]
        + ((row_c == col_c) ? (M_W'(1) << SCALE_SHIFT) : '0);

    plo_c = T_W'(quo_q[0][N_W-1:0]) * T_W'(KERNEL_SCALE);
    phi_c = (P_W + 1)'(quo_q[0][INV_SHIFT:N_W]) * (P_W + 1)'(KERNEL_SCALE)
          + (P_W + 1)'(t_q[N_W+K_W-1:N_W]);
    glo_c = T_W'(p_q[SCALE_SHIFT-1:0]) * T_W'(m_q);
    ghi_c = (G_W + 1)'(p_q[P_W-1:SCALE_SHIFT]) * (G_W + 1)'(m_q)
          + (G_W + 1)'(t_q[T_W-1:SCALE_SHIFT]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= K_IDLE;
      cnt_q   <= '0;
      ent_q   <= '0;
      done_q  <= 1'b0;
      cval_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      cval_q <= 1'b0;
      unique case (state_q)
        K_IDLE: begin
          if (start_i) begin
            state_q <= K_SQUARE;
            cnt_q   <= '0;
          end
        end
        K_SQUARE: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(2)) begin
            cnt_q   <= '0;
            state_q <= K_CHECK;
          end
        end
        K_CHECK: begin
          if (too_close_c) begin
            done_q  <= 1'b1;
            state_q <= K_IDLE;
          end else begin
            cnt_q   <= '0;
            state_q <= K_SQRT;
          end
        end
        K_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
            cnt_q <= '0;
            if (res_nx[N_W-1:0] == '0) begin
              done_q  <= 1'b1;
              state_q <= K_IDLE;
            end else begin
              state_q <= K_DIVIDE;
            end
          end
        end
        K_DIVIDE: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= K_PLO;
        end
        K_PLO: state_q <= K_PHI;
        K_PHI: begin
          ent_q   <= '0;
          state_q <= K_MPROD;
        end
        K_MPROD: state_q <= K_GLO;
        K_GLO:   state_q <= K_GHI;
        K_GHI: begin
          cval_q <= 1'b1;
          if (ent_q == ENTRY_W'(ENTRIES - 1)) begin
            done_q  <= 1'b1;
            state_q <= K_IDLE;
          end else begin
            ent_q   <= ent_q + 1'b1;
            state_q <= K_MPROD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      K_IDLE: begin
        if (start_i) begin
          for (int k = 0; k < 3; k++) begin
            a_q[k]   <= A_W'(mag_c[k] >> shift_c);
            neg_q[k] <= req_i.r[k][RX_W-1];
          end
          s_q  <= shift_c;
          d2_q <= '0;
        end
      end
      K_SQUARE: d2_q <= d2_q + D2_W'(sq_c);
      K_CHECK: begin
        x_q   <= d2_q;
        res_q <= '0;
        bit_q <= D2_W'(1) << (D2_W - 2);
      end
      K_SQRT: begin
        x_q   <= x_nx;
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        n_q   <= res_nx[N_W-1:0];
        num_q[0] <= DIV_W'(1) << (INV_SHIFT - int'(s_q));
        for (int k = 0; k < 3; k++) begin
          num_q[k+1] <= DIV_W'(a_q[k]) << SCALE_SHIFT;
        end
        for (int l = 0; l < 4; l++) begin
          rem_q[l] <= '0;
          quo_q[l] <= '0;
        end
      end
      K_DIVIDE: begin
        for (int l = 0; l < 4; l++) begin
          num_q[l] <= num_q[l] << 1;
          rem_q[l] <= ge_c[l] ? diff_c[l][N_W-1:0] : rem2_c[l][N_W-1:0];
          quo_q[l] <= {quo_q[l][DIV_W-2:0], ge_c[l]};
        end
      end
      K_PLO:   t_q <= plo_c;
      K_PHI:   p_q <= phi_c[P_W-1:0];
      K_MPROD: m_q <= m_c;
      K_GLO:   t_q <= glo_c;
      K_GHI: begin
        g_q      <= ghi_c[G_W-1:0];
        centry_q <= ent_q;
        cneg_q   <= (row_c != col_c) && (neg_q[row_c] != neg_q[col_c]);
      end
      default: ;
    endcase
  end

  assign contrib_o.valid  = cval_q;
  assign contrib_o.entry  = centry_q;
  assign contrib_o.negate = cneg_q;
  assign contrib_o.mag    = g_q;
  assign done_o           = done_q;

endmodule

`default_nettype wire

// ===== rtl/spis_back.sv =====
// ----------------------------------------------------------------------------
// spis_back: image sequencer and accumulator
// Walks the images selected by the opcode, starts the kernel for each, sums
// the six tensor entries and saturates them into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spis_back import spis_pkg::*; #(
  parameter int MAX_FAR_IMAGES  = DEF_MAX_FAR_IMAGES,
  parameter int MAX_NEAR_LAYERS = DEF_MAX_NEAR_LAYERS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      cmd_valid_i,
  input  wire cmd_t      cmd_i,
  output logic           cmd_pop_o,
  output logic           kstart_o,
  output kreq_t          kreq_o,
  input  wire contrib_t  contrib_i,
  input  wire logic      kdone_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output result_t        result_o
);

  localparam int FAR_LOG  = $clog2(MAX_FAR_IMAGES);
  localparam int NEAR_LOG = $clog2(MAX_NEAR_LAYERS + 1);
  localparam int IMG_W    = ((FAR_LOG > NEAR_LOG) ? FAR_LOG : NEAR_LOG) + 2;

  typedef enum logic [1:0] {B_IDLE, B_LAUNCH, B_WAIT, B_DONE} bstate_e;

  bstate_e                   state_q;
  logic [OPCODE_W-1:0]       op_q;
  logic [2:0][DIFF_W-1:0]    d_q;
  logic signed [IMG_W-1:0]   i_q;
  logic                      phase_q;
  logic signed [SUM_W-1:0]   sum_q [ENTRIES];
  logic                      out_valid_q;
  result_t                   result_q;

  logic signed [IMG_W-1:0]   nl_eff, fl_eff;
  logic signed [RX_W-1:0]    offset, dx_ext;
  logic                      load_out;
  result_t                   sat_c;
  logic [SUM_W-1:0]          ext_c;

  always_comb begin
    nl_eff = (int'(cfg_i.near_layers) > MAX_NEAR_LAYERS) ? IMG_W'(MAX_NEAR_LAYERS)
                                                          : IMG_W'(cfg_i.near_layers);
    fl_eff = (int'(cfg_i.far_limit) > MAX_FAR_IMAGES) ? IMG_W'(MAX_FAR_IMAGES)
                                                       : IMG_W'(cfg_i.far_limit);
    offset = RX_W'(i_q) <<< PERIOD_SHIFT;
    dx_ext = {d_q[0][DIFF_W-1], d_q[0]};
    kreq_o.r[0] = phase_q ? (dx_ext + offset) : (dx_ext - offset);
    kreq_o.r[1] = {d_q[1][DIFF_W-1], d_q[1]};
    kreq_o.r[2] = {d_q[2][DIFF_W-1], d_q[2]};
    ext_c = SUM_W'(contrib_i.mag);
    // Keep the sum when its upper bits agree, else clamp by its sign.
    for (int j = 0; j < ENTRIES; j++) begin
      if ((sum_q[j][SUM_W-1:OUT_W-1] == '0) || (sum_q[j][SUM_W-1:OUT_W-1] == '1)) begin
        sat_c[j] = sum_q[j][OUT_W-1:0];
      end else begin
        sat_c[j] = {sum_q[j][SUM_W-1], {(OUT_W - 1){~sum_q[j][SUM_W-1]}}};
      end
    end
  end

  assign cmd_pop_o   = (state_q == B_IDLE);
  assign kstart_o    = (state_q == B_LAUNCH);
  assign load_out    = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_SINGLE, OP_NEAR: state_q <= B_LAUNCH;
              OP_FAR:  state_q <= (fl_eff > nl_eff + IMG_W'(1)) ? B_LAUNCH : B_DONE;
              default: state_q <= B_DONE;
            endcase
          end
        end
        B_LAUNCH: state_q <= B_WAIT;
        B_WAIT: begin
          if (kdone_i) begin
            case (op_q)
              OP_NEAR: state_q <= (i_q == nl_eff) ? B_DONE : B_LAUNCH;
              OP_FAR: begin
                if (!phase_q)                      state_q <= B_LAUNCH;
                else if (i_q == fl_eff - IMG_W'(1)) state_q <= B_DONE;
                else                               state_q <= B_LAUNCH;
              end
              default: state_q <= B_DONE;
            endcase
          end
        end
        B_DONE: begin
          if (load_out) state_q <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && cmd_valid_i) begin
      op_q    <= cmd_i.op;
      d_q     <= cmd_i.d;
      phase_q <= 1'b0;
      case (cmd_i.op)
        OP_NEAR: i_q <= -nl_eff;
        OP_FAR:  i_q <= nl_eff + IMG_W'(1);
        default: i_q <= '0;
      endcase
      for (int j = 0; j < ENTRIES; j++) sum_q[j] <= '0;
    end else begin
      if (state_q == B_WAIT && kdone_i) begin
        if (op_q == OP_FAR) begin
          phase_q <= ~phase_q;
          if (phase_q) i_q <= i_q + IMG_W'(1);
        end else begin
          i_q <= i_q + IMG_W'(1);
        end
      end
      for (int j = 0; j < ENTRIES; j++) begin
        if (contrib_i.valid && contrib_i.entry == ENTRY_W'(j)) begin
          sum_q[j] <= contrib_i.negate ? (sum_q[j] - $signed(ext_c))
                                       : (sum_q[j] + $signed(ext_c));
        end
      end
    end
    if (load_out) result_q <= sat_c;
  end

endmodule

`default_nettype wire

// ===== rtl/stokeslet_periodic_image_sum.sv =====
// ----------------------------------------------------------------------------
// stokeslet_periodic_image_sum: Oseen tensor summed over periodic x images
// Top level: configuration registers, input queue, image sequencer, kernel.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_i (opcode, target and source in Q16.16). Each item gives
// one result item on out_o: the six distinct tensor entries in Q16.32,
// saturated to 48 bits. Configuration is written on cfg_i, one register per
// write (min_distance, near_layers, far_limit); the user must write it only
// while the block is idle; the block itself does not enforce this. The
// kernel evaluates one image with its 32-step square root and its 64-step
// dividers. An item runs one image for opcode 0, 2*N+1 for opcode 1 and
// 2*(F-N-1) for opcode 2; an empty far range or opcode 3 runs none.
// A two-entry queue takes new items while the sequencer works, and the
// result register lets the next item start while a result waits.
// When the receiver stalls, the finished sum waits in the sequencer until
// the result register frees. Reset restores the register defaults and
// empties the queue and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stokeslet_periodic_image_sum import spis_pkg::*; #(
  parameter int MAX_FAR_IMAGES  = DEF_MAX_FAR_IMAGES,
  parameter int MAX_NEAR_LAYERS = DEF_MAX_NEAR_LAYERS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spis_in_if.sink     in_i,
  spis_out_if.source  out_o,
  spis_cfg_if.sink    cfg_i
);

  cfg_t      cfg_q;
  logic      cmd_valid, cmd_pop, kstart, kdone;
  cmd_t      cmd;
  kreq_t     kreq;
  contrib_t  contrib;
  result_t   result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance <= MIN_DISTANCE_RST;
      cfg_q.near_layers  <= NEAR_LAYERS_RST;
      cfg_q.far_limit    <= FAR_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CFG_MIN_DISTANCE: cfg_q.min_distance <= cfg_i.data[MIN_DIST_W-1:0];
        CFG_NEAR_LAYERS:  cfg_q.near_layers  <= cfg_i.data[NEAR_W-1:0];
        CFG_FAR_LIMIT:    cfg_q.far_limit    <= cfg_i.data[FAR_W-1:0];
        default: ;
      endcase
    end
  end

  spis_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  spis_back #(
    .MAX_FAR_IMAGES  (MAX_FAR_IMAGES),
    .MAX_NEAR_LAYERS (MAX_NEAR_LAYERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .kstart_o    (kstart),
    .kreq_o      (kreq),
    .contrib_i   (contrib),
    .kdone_i     (kdone),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

  spis_kernel u_kernel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (kstart),
    .req_i          (kreq),
    .min_distance_i (cfg_q.min_distance),
    .contrib_o      (contrib),
    .done_o         (kdone)
  );

  assign out_o.g_xx = result[0];
  assign out_o.g_xy = result[1];
  assign out_o.g_xz = result[2];
  assign out_o.g_yy = result[3];
  assign out_o.g_yz = result[4];
  assign out_o.g_zz = result[5];

endmodule

`default_nettype wire
